// File: hw/rtl/leg_inverse_kinematics_defines.svh
// Assertion helpers for the leg inverse kinematics block.
// Used by the top level only; depends on nothing else.
`ifndef LEG_INVERSE_KINEMATICS_DEFINES_SVH
`define LEG_INVERSE_KINEMATICS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LIK_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIK_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lik_pkg.sv
// Shared widths, constants and the arctangent table of the leg IK block.
// No dependencies; used by the CORDIC cell and by the top level.
package lik_pkg;

  // Default CORDIC depth
  localparam int CORDIC_STAGES = 16;

  // Field widths
  localparam int XY_W    = 16;
  localparam int CFG_W   = 15;
  localparam int SWEEP_W = 17;
  localparam int ADD_W   = 15;

  // Datapath widths
  localparam int SQ1_W      = 48;  // (x^2 + y^2) << 16
  localparam int DLEN_W     = 25;  // signed d = L - l3
  localparam int DMAG_W     = 24;
  localparam int DD_W       = 48;
  localparam int LD_W       = 39;
  localparam int NUM_W      = 49;
  localparam int DEN_W      = 48;
  localparam int NORM_FLOOR = 30;  // den is shifted until below 2^30
  localparam int CLAMP_W    = 32;
  localparam int FAC_W      = 31;
  localparam int SQ2_W      = 62;
  localparam int ROOT2_W    = 31;
  localparam int SWEEP_DW   = 35;
  localparam int GAMMA_DW   = 51;
  localparam int ZW         = 21;  // Q.16 angle accumulator
  localparam int ATAN_W     = 17;
  localparam int THETA_W    = 19;
  localparam int SQDIFF_W   = 31;

  // Register reset values
  localparam logic [CFG_W-1:0] FLIPPER_RESET    = 15'd4260;
  localparam logic [CFG_W-1:0] HIP_HEIGHT_RESET = 15'd2589;
  localparam logic [CFG_W-1:0] HIP_OFFSET_RESET = 15'd1802;

  // Angle constants
  localparam logic signed [ZW-1:0]      PI_Q16          = 21'sd205887;
  localparam logic signed [ZW-1:0]      ROUND_Q13       = 21'sd4;
  localparam logic signed [THETA_W-1:0] NEG_HALF_PI_Q13 = -19'sd12868;
  localparam logic signed [THETA_W-1:0] TWO_PI_Q13      = 19'sd51472;
  localparam logic signed [ZW-1:0]      PI_Q13          = 21'sd25736;
  localparam logic [ADD_W-1:0]          PI_Q13_U        = 15'd25736;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_FLIPPER    = 2'd0,
    CFG_HIP_HEIGHT = 2'd1,
    CFG_HIP_OFFSET = 2'd2
  } cfg_index_t;

  // atan(2^-i) * 2^16, rounded; zero from i = 17 on
  function automatic logic [ATAN_W-1:0] atan_entry(input int i);
    logic [ATAN_W-1:0] a;
    case (i)
      0:       a = 17'd51472;
      1:       a = 17'd30386;
      2:       a = 17'd16055;
      3:       a = 17'd8150;
      4:       a = 17'd4091;
      5:       a = 17'd2047;
      6:       a = 17'd1024;
      7:       a = 17'd512;
      8:       a = 17'd256;
      9:       a = 17'd128;
      10:      a = 17'd64;
      11:      a = 17'd32;
      12:      a = 17'd16;
      13:      a = 17'd8;
      14:      a = 17'd4;
      15:      a = 17'd2;
      16:      a = 17'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: hw/rtl/lik_sqrt_cell.sv
// One step of the digit-by-digit integer square root, one root bit per cell.
// Depends on nothing; chained by the top level.
module lik_sqrt_cell #(
  parameter int W      = 48,
  parameter int IDX    = 0,
  parameter int SIDE_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              valid_in,
  input  logic [W-1:0]      rem_in,
  input  logic [W-1:0]      root_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [W-1:0]      rem_out,
  output logic [W-1:0]      root_out,
  output logic [SIDE_W-1:0] side_out
);

  // bit weight handled by this cell
  localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2*IDX);

  logic [W:0]   trial;
  logic [W-1:0] rem_next;
  logic [W-1:0] root_next;

  assign trial = {1'b0, root_in} + {1'b0, BIT};

  // trial subtract
  always_comb begin
    if ({1'b0, rem_in} >= trial) begin
      rem_next  = rem_in - trial[W-1:0];
      root_next = (root_in >> 1) + BIT;
    end else begin
      rem_next  = rem_in;
      root_next = root_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out  <= rem_next;
      root_out <= root_next;
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/lik_norm_cell.sv
// One scaling step: halves num and den while den is at or above the floor.
// Depends on nothing; chained by the top level.
module lik_norm_cell #(
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 48,
  parameter int FLOOR  = 30,
  parameter int SIDE_W = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    valid_in,
  input  logic signed [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0]        den_in,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    valid_out,
  output logic signed [NUM_W-1:0] num_out,
  output logic [DEN_W-1:0]        den_out,
  output logic [SIDE_W-1:0]       side_out
);

  logic big;

  assign big = |den_in[DEN_W-1:FLOOR];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  // arithmetic shift floors num, matching a single combined shift
  always_ff @(posedge clk) begin
    if (adv) begin
      num_out  <= big ? (num_in >>> 1) : num_in;
      den_out  <= big ? (den_in >> 1) : den_in;
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/lik_cordic_cell.sv
// One CORDIC vectoring rotation with a fixed shift and arctangent step.
// Depends on lik_pkg for the arctangent table.
module lik_cordic_cell #(
  parameter int DW     = 51,
  parameter int ZW     = 21,
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 valid_in,
  input  logic signed [DW-1:0] u_in,
  input  logic signed [DW-1:0] v_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 valid_out,
  output logic signed [DW-1:0] u_out,
  output logic signed [DW-1:0] v_out,
  output logic signed [ZW-1:0] z_out,
  output logic [SIDE_W-1:0]    side_out
);

  localparam logic signed [ZW-1:0] ANG =
    $signed({{(ZW-lik_pkg::ATAN_W){1'b0}}, lik_pkg::atan_entry(IDX)});

  logic signed [DW-1:0] du;
  logic signed [DW-1:0] dv;

  assign du = v_in >>> IDX;
  assign dv = u_in >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  // rotate toward v = 0
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!v_in[DW-1]) begin
        u_out <= u_in + du;
        v_out <= v_in - dv;
        z_out <= z_in + ANG;
      end else begin
        u_out <= u_in - du;
        v_out <= v_in + dv;
        z_out <= z_in - ANG;
      end
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/leg_inverse_kinematics.sv
// Leg inverse kinematics top level: sweep angle atan2(x, y) and adduction
// angle by the law of cosines. Depends on lik_pkg, the three cell modules
// and leg_inverse_kinematics_defines.svh.
// Input channel in_valid/in_ready carries a toe word (toe_x, toe_y).
// Output channel out_valid/out_ready carries sweep_angle, adduction_angle
// and adduction_valid. Config channel cfg_valid/cfg_ready writes
// cfg_data into register cfg_index; cfg_ready is always high.
// The path from acceptance to out_valid runs through the two root chains
// (24 and 31 cells), the 18 scaling cells and the CORDIC chain. Throughput:
// one word per cycle while no finished result waits on a stalled output.
// The whole chain advances together; it keeps moving while the last stage
// is empty or the output register is free, so bubbles are squeezed out
// while a result waits. It stops only when a finished result sits behind
// a stalled output register; in_ready then drops.
// Reset clears all valid flags and loads the default link lengths.
`include "leg_inverse_kinematics_defines.svh"

module leg_inverse_kinematics #(
  parameter int CORDIC_STAGES = lik_pkg::CORDIC_STAGES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lik_pkg::XY_W-1:0]   toe_x,
  input  logic signed [lik_pkg::XY_W-1:0]   toe_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lik_pkg::SWEEP_W-1:0] sweep_angle,
  output logic [lik_pkg::ADD_W-1:0]         adduction_angle,
  output logic                              adduction_valid,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [lik_pkg::CFG_W-1:0]         cfg_data
);

  localparam int XY_W     = lik_pkg::XY_W;
  localparam int CFG_W    = lik_pkg::CFG_W;
  localparam int SQ1_W    = lik_pkg::SQ1_W;
  localparam int N1       = SQ1_W / 2;
  localparam int SQ2_W    = lik_pkg::SQ2_W;
  localparam int N2       = SQ2_W / 2;
  localparam int NUM_W    = lik_pkg::NUM_W;
  localparam int DEN_W    = lik_pkg::DEN_W;
  localparam int NFLOOR   = lik_pkg::NORM_FLOOR;
  localparam int NN       = DEN_W - NFLOOR;
  localparam int CLAMP_W  = lik_pkg::CLAMP_W;
  localparam int FAC_W    = lik_pkg::FAC_W;
  localparam int ROOT2_W  = lik_pkg::ROOT2_W;
  localparam int SDW      = lik_pkg::SWEEP_DW;
  localparam int GDW      = lik_pkg::GAMMA_DW;
  localparam int ZW       = lik_pkg::ZW;
  localparam int THETA_W  = lik_pkg::THETA_W;
  localparam int XYS_W    = 2 * XY_W;
  localparam int OKS_W    = XYS_W + 1;
  localparam int NUMS_W   = OKS_W + CLAMP_W;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [CFG_W-1:0]                    flipper_length;
  logic [CFG_W-1:0]                    hip_height;
  logic [CFG_W-1:0]                    hip_offset;
  logic signed [lik_pkg::SQDIFF_W-1:0] sqdiff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flipper_length <= lik_pkg::FLIPPER_RESET;
      hip_height     <= lik_pkg::HIP_HEIGHT_RESET;
      hip_offset     <= lik_pkg::HIP_OFFSET_RESET;
    end else if (cfg_valid) begin
      unique case (lik_pkg::cfg_index_t'(cfg_index))
        lik_pkg::CFG_FLIPPER:    flipper_length <= cfg_data;
        lik_pkg::CFG_HIP_HEIGHT: hip_height     <= cfg_data;
        lik_pkg::CFG_HIP_OFFSET: hip_offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  // l1^2 - l2^2, refreshed every cycle from the registers
  logic [2*CFG_W-1:0] l1_sq;
  logic [2*CFG_W-1:0] l2_sq;
  assign l1_sq = flipper_length * flipper_length;
  assign l2_sq = hip_height * hip_height;

  always_ff @(posedge clk) begin
    sqdiff <= $signed({1'b0, l1_sq}) - $signed({1'b0, l2_sq});
  end

  // ---------------------------------------------------------------
  // Global advance
  logic advance;
  logic last_valid;

  assign advance  = !last_valid || !out_valid || out_ready;
  assign in_ready = advance;

  // ---------------------------------------------------------------
  // Stage 1: squared radius
  logic signed [2*XY_W-1:0] xx;
  logic signed [2*XY_W-1:0] yy;
  logic [2*XY_W-1:0]        rsq;
  logic                     s1_valid;
  logic [SQ1_W-1:0]         s1_rem;
  logic [XYS_W-1:0]         s1_side;

  assign xx  = toe_x * toe_x;
  assign yy  = toe_y * toe_y;
  assign rsq = {1'b0, xx[2*XY_W-2:0]} + {1'b0, yy[2*XY_W-2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rem  <= {rsq, {(SQ1_W-2*XY_W){1'b0}}};
      s1_side <= {toe_x, toe_y};
    end
  end

  // ---------------------------------------------------------------
  // Root chain 1: L = sqrt(r^2 << 16)
  logic             q1_valid [0:N1];
  logic [SQ1_W-1:0] q1_rem   [0:N1];
  logic [SQ1_W-1:0] q1_root  [0:N1];
  logic [XYS_W-1:0] q1_side  [0:N1];

  assign q1_valid[0] = s1_valid;
  assign q1_rem[0]   = s1_rem;
  assign q1_root[0]  = '0;
  assign q1_side[0]  = s1_side;

  for (genvar i = 0; i < N1; i++) begin : g_root1
    lik_sqrt_cell #(.W(SQ1_W), .IDX(i), .SIDE_W(XYS_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (advance),
      .valid_in  (q1_valid[i]),
      .rem_in    (q1_rem[i]),
      .root_in   (q1_root[i]),
      .side_in   (q1_side[i]),
      .valid_out (q1_valid[i+1]),
      .rem_out   (q1_rem[i+1]),
      .root_out  (q1_root[i+1]),
      .side_out  (q1_side[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Stage 2: d = L - l3 << 8
  logic                             s2_valid;
  logic signed [lik_pkg::DLEN_W-1:0] s2_d;
  logic [XYS_W-1:0]                 s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= q1_valid[N1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_d    <= $signed({1'b0, q1_root[N1][lik_pkg::DMAG_W-1:0]})
               - $signed({2'b00, hip_offset, 8'b0});
      s2_side <= q1_side[N1];
    end
  end

  // Stage 3: d^2 and l1*d
  logic                      s3_valid;
  logic                      s3_dpos;
  logic [lik_pkg::DD_W-1:0]  s3_dd;
  logic [lik_pkg::LD_W-1:0]  s3_ld;
  logic [XYS_W-1:0]          s3_side;
  logic [lik_pkg::DMAG_W-1:0] dmag;

  assign dmag = s2_d[lik_pkg::DMAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_dpos <= !s2_d[lik_pkg::DLEN_W-1] && (s2_d != '0);
      s3_dd   <= dmag * dmag;
      s3_ld   <= flipper_length * dmag;
      s3_side <= s2_side;
    end
  end

  // Stage 4: num and den
  logic                    s4_valid;
  logic                    s4_dpos;
  logic signed [NUM_W-1:0] s4_num;
  logic [DEN_W-1:0]        s4_den;
  logic [XYS_W-1:0]        s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_dpos <= s3_dpos;
      s4_num  <= $signed({1'b0, s3_dd})
               + $signed({{(NUM_W-lik_pkg::SQDIFF_W-16){sqdiff[lik_pkg::SQDIFF_W-1]}},
                          sqdiff, 16'b0});
      s4_den  <= {s3_ld, {(DEN_W-lik_pkg::LD_W){1'b0}}};
      s4_side <= s3_side;
    end
  end

  // Stage 5: acos argument range check
  logic signed [NUM_W:0]   nd_sum;
  logic                    arg_ok;
  logic                    s5_valid;
  logic signed [NUM_W-1:0] s5_num;
  logic [DEN_W-1:0]        s5_den;
  logic [OKS_W-1:0]        s5_side;

  assign nd_sum = $signed({s4_num[NUM_W-1], s4_num}) + $signed({2'b00, s4_den});
  assign arg_ok = s4_dpos && (s4_den != '0) &&
                  (s4_num[NUM_W-1] ? !nd_sum[NUM_W] : (s4_num[DEN_W-1:0] <= s4_den));

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (advance) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_num  <= s4_num;
      s5_den  <= s4_den;
      s5_side <= {s4_side, arg_ok};
    end
  end

  // ---------------------------------------------------------------
  // Scaling chain: den below 2^30
  logic                    nm_valid [0:NN];
  logic signed [NUM_W-1:0] nm_num   [0:NN];
  logic [DEN_W-1:0]        nm_den   [0:NN];
  logic [OKS_W-1:0]        nm_side  [0:NN];

  assign nm_valid[0] = s5_valid;
  assign nm_num[0]   = s5_num;
  assign nm_den[0]   = s5_den;
  assign nm_side[0]  = s5_side;

  for (genvar i = 0; i < NN; i++) begin : g_norm
    lik_norm_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .FLOOR(NFLOOR), .SIDE_W(OKS_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (advance),
      .valid_in  (nm_valid[i]),
      .num_in    (nm_num[i]),
      .den_in    (nm_den[i]),
      .side_in   (nm_side[i]),
      .valid_out (nm_valid[i+1]),
      .num_out   (nm_num[i+1]),
      .den_out   (nm_den[i+1]),
      .side_out  (nm_side[i+1])
    );
  end

  // Stage 6: clamp num to [-den, den]
  logic signed [CLAMP_W-1:0] nn_num;
  logic signed [CLAMP_W-1:0] nn_den;
  logic signed [CLAMP_W-1:0] nn_nden;
  logic                      s6_valid;
  logic signed [CLAMP_W-1:0] s6_num;
  logic signed [CLAMP_W-1:0] s6_den;
  logic [OKS_W-1:0]          s6_side;

  assign nn_num  = nm_num[NN][CLAMP_W-1:0];
  assign nn_den  = $signed({{(CLAMP_W-NFLOOR){1'b0}}, nm_den[NN][NFLOOR-1:0]});
  assign nn_nden = -nn_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (advance) begin
      s6_valid <= nm_valid[NN];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (nn_num > nn_den) begin
        s6_num <= nn_den;
      end else if (nn_num < nn_nden) begin
        s6_num <= nn_nden;
      end else begin
        s6_num <= nn_num;
      end
      s6_den  <= nn_den;
      s6_side <= nm_side[NN];
    end
  end

  // Stage 7: den - num and den + num
  logic [CLAMP_W-1:0] fa;
  logic [CLAMP_W-1:0] fb;
  logic               s7_valid;
  logic [FAC_W-1:0]   s7_a;
  logic [FAC_W-1:0]   s7_b;
  logic [NUMS_W-1:0]  s7_side;

  assign fa = s6_den - s6_num;
  assign fb = s6_den + s6_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (advance) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s7_a    <= fa[FAC_W-1:0];
      s7_b    <= fb[FAC_W-1:0];
      s7_side <= {s6_side, s6_num};
    end
  end

  // Stage 8: den^2 - num^2
  logic              s8_valid;
  logic [SQ2_W-1:0]  s8_prod;
  logic [NUMS_W-1:0] s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (advance) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s8_prod <= s7_a * s7_b;
      s8_side <= s7_side;
    end
  end

  // ---------------------------------------------------------------
  // Root chain 2: s = sqrt(den^2 - num^2)
  logic              q2_valid [0:N2];
  logic [SQ2_W-1:0]  q2_rem   [0:N2];
  logic [SQ2_W-1:0]  q2_root  [0:N2];
  logic [NUMS_W-1:0] q2_side  [0:N2];

  assign q2_valid[0] = s8_valid;
  assign q2_rem[0]   = s8_prod;
  assign q2_root[0]  = '0;
  assign q2_side[0]  = s8_side;

  for (genvar i = 0; i < N2; i++) begin : g_root2
    lik_sqrt_cell #(.W(SQ2_W), .IDX(i), .SIDE_W(NUMS_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (advance),
      .valid_in  (q2_valid[i]),
      .rem_in    (q2_rem[i]),
      .root_in   (q2_root[i]),
      .side_in   (q2_side[i]),
      .valid_out (q2_valid[i+1]),
      .rem_out   (q2_rem[i+1]),
      .root_out  (q2_root[i+1]),
      .side_out  (q2_side[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Stage 9: CORDIC setup for both vectors
  logic signed [XY_W-1:0]    px;
  logic signed [XY_W-1:0]    py;
  logic                      pok;
  logic signed [CLAMP_W-1:0] pnum;
  logic [ROOT2_W-1:0]        proot;
  logic signed [SDW-1:0]     su_sc;
  logic signed [SDW-1:0]     sv_sc;
  logic signed [GDW-1:0]     gu_sc;
  logic signed [GDW-1:0]     gv_sc;

  logic                  s9_valid;
  logic signed [SDW-1:0] s9_su;
  logic signed [SDW-1:0] s9_sv;
  logic signed [ZW-1:0]  s9_sz;
  logic                  s9_szero;
  logic signed [GDW-1:0] s9_gu;
  logic signed [GDW-1:0] s9_gv;
  logic signed [ZW-1:0]  s9_gz;
  logic [1:0]            s9_gside;

  assign {px, py, pok, pnum} = q2_side[N2];
  assign proot = q2_root[N2][ROOT2_W-1:0];
  assign su_sc = $signed({{(SDW-XY_W-16){py[XY_W-1]}}, py, 16'b0});
  assign sv_sc = $signed({{(SDW-XY_W-16){px[XY_W-1]}}, px, 16'b0});
  assign gu_sc = $signed({{(GDW-CLAMP_W-16){pnum[CLAMP_W-1]}}, pnum, 16'b0});
  assign gv_sc = $signed({{(GDW-ROOT2_W-16){1'b0}}, proot, 16'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (advance) begin
      s9_valid <= q2_valid[N2];
    end
  end

  // left half plane: negate and start from +-pi
  always_ff @(posedge clk) begin
    if (advance) begin
      s9_szero <= (px == '0) && (py == '0);
      if (py[XY_W-1]) begin
        s9_su <= -su_sc;
        s9_sv <= -sv_sc;
        s9_sz <= px[XY_W-1] ? -lik_pkg::PI_Q16 : lik_pkg::PI_Q16;
      end else begin
        s9_su <= su_sc;
        s9_sv <= sv_sc;
        s9_sz <= '0;
      end
      s9_gside <= {pok, (pnum == '0) && (proot == '0)};
      if (pnum[CLAMP_W-1]) begin
        s9_gu <= -gu_sc;
        s9_gv <= -gv_sc;
        s9_gz <= lik_pkg::PI_Q16;
      end else begin
        s9_gu <= gu_sc;
        s9_gv <= gv_sc;
        s9_gz <= '0;
      end
    end
  end

  // ---------------------------------------------------------------
  // CORDIC chains, sweep and adduction side by side
  logic                  cs_valid [0:CORDIC_STAGES];
  logic signed [SDW-1:0] cs_u     [0:CORDIC_STAGES];
  logic signed [SDW-1:0] cs_v     [0:CORDIC_STAGES];
  logic signed [ZW-1:0]  cs_z     [0:CORDIC_STAGES];
  logic                  cs_side  [0:CORDIC_STAGES];
  logic                  cg_valid [0:CORDIC_STAGES];
  logic signed [GDW-1:0] cg_u     [0:CORDIC_STAGES];
  logic signed [GDW-1:0] cg_v     [0:CORDIC_STAGES];
  logic signed [ZW-1:0]  cg_z     [0:CORDIC_STAGES];
  logic [1:0]            cg_side  [0:CORDIC_STAGES];

  assign cs_valid[0] = s9_valid;
  assign cs_u[0]     = s9_su;
  assign cs_v[0]     = s9_sv;
  assign cs_z[0]     = s9_sz;
  assign cs_side[0]  = s9_szero;
  assign cg_valid[0] = s9_valid;
  assign cg_u[0]     = s9_gu;
  assign cg_v[0]     = s9_gv;
  assign cg_z[0]     = s9_gz;
  assign cg_side[0]  = s9_gside;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    lik_cordic_cell #(.DW(SDW), .ZW(ZW), .IDX(i), .SIDE_W(1)) u_sweep (
      .clk       (clk),
      .rst       (rst),
      .adv       (advance),
      .valid_in  (cs_valid[i]),
      .u_in      (cs_u[i]),
      .v_in      (cs_v[i]),
      .z_in      (cs_z[i]),
      .side_in   (cs_side[i]),
      .valid_out (cs_valid[i+1]),
      .u_out     (cs_u[i+1]),
      .v_out     (cs_v[i+1]),
      .z_out     (cs_z[i+1]),
      .side_out  (cs_side[i+1])
    );
    lik_cordic_cell #(.DW(GDW), .ZW(ZW), .IDX(i), .SIDE_W(2)) u_gamma (
      .clk       (clk),
      .rst       (rst),
      .adv       (advance),
      .valid_in  (cg_valid[i]),
      .u_in      (cg_u[i]),
      .v_in      (cg_v[i]),
      .z_in      (cg_z[i]),
      .side_in   (cg_side[i]),
      .valid_out (cg_valid[i+1]),
      .u_out     (cg_u[i+1]),
      .v_out     (cg_v[i+1]),
      .z_out     (cg_z[i+1]),
      .side_out  (cg_side[i+1])
    );
  end

  assign last_valid = cs_valid[CORDIC_STAGES] && cg_valid[CORDIC_STAGES];

  // ---------------------------------------------------------------
  // Output stage: Q.16 to Q3.13, sweep wrap, adduction clamp
  logic signed [ZW-1:0]      zs_q13;
  logic signed [ZW-1:0]      zg_q13;
  logic signed [THETA_W-1:0] theta;
  logic signed [THETA_W-1:0] theta_wrap;
  logic [lik_pkg::ADD_W-1:0] gamma;
  logic                      g_ok;
  logic                      g_zero;

  assign zs_q13 = (cs_z[CORDIC_STAGES] + lik_pkg::ROUND_Q13) >>> 3;
  assign zg_q13 = (cg_z[CORDIC_STAGES] + lik_pkg::ROUND_Q13) >>> 3;
  assign {g_ok, g_zero} = cg_side[CORDIC_STAGES];

  always_comb begin
    theta = cs_side[CORDIC_STAGES] ? '0 : zs_q13[THETA_W-1:0];
    if (theta < lik_pkg::NEG_HALF_PI_Q13) begin
      theta_wrap = theta + lik_pkg::TWO_PI_Q13;
    end else begin
      theta_wrap = theta;
    end
    if (!g_ok || g_zero || zg_q13[ZW-1]) begin
      gamma = '0;
    end else if (zg_q13 > lik_pkg::PI_Q13) begin
      gamma = lik_pkg::PI_Q13_U;
    end else begin
      gamma = zg_q13[lik_pkg::ADD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      sweep_angle     <= theta_wrap[lik_pkg::SWEEP_W-1:0];
      adduction_angle <= gamma;
      adduction_valid <= g_ok;
    end
  end

  // ---------------------------------------------------------------
  // Checks
  `LIK_ASSERT_NEXT(a_accept_captured, clk, rst, in_valid && in_ready, s1_valid,
    "accepted word not captured")
  `LIK_ASSERT_NEXT(a_stall_keeps_last, clk, rst,
    last_valid && out_valid && !out_ready, last_valid && out_valid,
    "finished word lost while output stalled")
  `LIK_ASSERT_NOW(a_gamma_bound, clk, rst, out_valid && adduction_valid,
    adduction_angle <= lik_pkg::PI_Q13_U, "adduction angle above pi")

endmodule
